// File: rtl/wav_riff_header_parser_defines.svh
// assertion macros used by the checker file
`ifndef WAV_RIFF_HEADER_PARSER_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define WRP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wrp check failed");

// next-cycle implication, sampled on clk, off during rst
`define WRP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wrp check failed");

`endif

// File: rtl/wrp_pkg.sv
`default_nettype none

package wrp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       restart;
    logic       stream_end;
  } wrp_item_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_SHORT_HEADER  = 3'd1,
    ST_NOT_RIFF_WAVE = 3'd2,
    ST_MISSING_DATA  = 3'd3,
    ST_BAD_FMT       = 3'd4,
    ST_NON_PCM       = 3'd5,
    ST_INCOMPLETE    = 3'd6,
    ST_BAD_BITS      = 3'd7
  } wrp_status_t;

  typedef enum logic [2:0] {
    PH_HEAD     = 3'd0,
    PH_HEAD_BAD = 3'd1,
    PH_CHUNK    = 3'd2,
    PH_FMT      = 3'd3,
    PH_SKIP     = 3'd4
  } wrp_phase_t;

  localparam logic [1:0] FMT_S16 = 2'd0;
  localparam logic [1:0] FMT_S24 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;

  typedef struct packed {
    wrp_status_t status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] payload_size;
    logic [32:0] data_offset;
    logic [1:0]  sample_format;
  } wrp_result_t;

  typedef struct packed {
    logic        valid;
    wrp_result_t result;
  } wrp_emit_t;

  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam logic [15:0] FORMAT_PCM = 16'd1;
  localparam logic [15:0] BITS_16    = 16'd16;
  localparam logic [15:0] BITS_24    = 16'd24;
  localparam logic [15:0] BITS_32    = 16'd32;

  localparam logic [32:0] HEAD_RIFF_END = 33'd4;
  localparam logic [32:0] HEAD_END      = 33'd12;
  localparam logic [32:0] CHUNK_HDR_END = 33'd8;
  localparam logic [32:0] FMT_TAG_END   = 33'd2;
  localparam logic [32:0] FMT_CH_END    = 33'd4;
  localparam logic [32:0] FMT_RATE_END  = 33'd8;
  localparam logic [32:0] FMT_END       = 33'd16;
  localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;

endpackage

`default_nettype wire

// File: rtl/wav_riff_header_parser.sv
// RIFF/WAVE header parser. One file byte per transaction on the item channel, one byte
// per clock sustained while nothing stalls; a byte enters an input register, the parse
// logic updates the chunk state from it when the byte is taken and any result is written
// to an output register in that same update. The parse step stalls only when a result is
// waiting and the result channel is not ready; the input register holds one
// more byte meanwhile. Each file yields at most one result (ok, error or metadata at
// the data chunk header); later bytes are consumed silently until an item with restart set.
`default_nettype none

module wav_riff_header_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  wrp_pkg::wrp_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output wrp_pkg::wrp_result_t result
);
  import wrp_pkg::*;

  logic      full;
  logic      take;
  wrp_item_t held;
  wrp_emit_t emit;

  assign take = full && (!result_valid || result_ready);

  wrp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (take),
    .full       (full),
    .held       (held)
  );

  wrp_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (held),
    .emit (emit)
  );

  wrp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .emit         (emit),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: rtl/wrp_in_reg.sv
`default_nettype none

module wrp_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  wrp_pkg::wrp_item_t item,
  input  logic              take,
  output logic              full,
  output wrp_pkg::wrp_item_t held
);
  import wrp_pkg::*;

  // a held transaction leaves on take, so a new one may enter the same cycle
  assign item_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_ready) begin
      full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wrp_parser.sv
`default_nettype none

module wrp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  wrp_pkg::wrp_item_t item,
  output wrp_pkg::wrp_emit_t emit
);
  import wrp_pkg::*;

  typedef struct packed {
    wrp_phase_t  phase;
    logic [32:0] count;
    logic [63:0] window;
    logic [32:0] position;
    logic [31:0] chunk_len;
    logic [15:0] format_tag;
    logic [15:0] held_channels;
    logic [31:0] held_rate;
    logic [15:0] held_bits;
    logic        format_seen;
    logic        finished;
  } wrp_state_t;

  localparam wrp_state_t STATE_RESET = '0;

  wrp_state_t state;
  wrp_state_t state_next;
  wrp_state_t cur;
  logic [63:0] win;
  logic [32:0] cnt_inc;
  logic [15:0] le16;
  logic [31:0] le32;
  logic [32:0] skip_chunk;
  logic [32:0] skip_fmt;
  wrp_status_t data_status;
  logic [1:0]  format_code;

  function automatic wrp_result_t error_result(input wrp_status_t st);
    wrp_result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  always_comb begin
    cur        = item.restart ? STATE_RESET : state;
    win        = {cur.window[55:0], item.byte_value};
    cnt_inc    = cur.count + 33'd1;
    le16       = {win[7:0], win[15:8]};
    le32       = {win[7:0], win[15:8], win[23:16], win[31:24]};
    skip_chunk = {1'b0, le32} + {32'd0, le32[0]};
    skip_fmt   = {1'b0, cur.chunk_len} - {1'b0, FMT_MIN_SIZE} + {32'd0, cur.chunk_len[0]};

    if (!cur.format_seen || cur.held_channels == '0 || cur.held_rate == '0 || le32 == '0) begin
      data_status = ST_INCOMPLETE;
    end else if (cur.held_bits != BITS_16 && cur.held_bits != BITS_24 &&
                 cur.held_bits != BITS_32) begin
      data_status = ST_BAD_BITS;
    end else begin
      data_status = ST_OK;
    end

    if (cur.held_bits == BITS_32) begin
      format_code = FMT_S32;
    end else if (cur.held_bits == BITS_24) begin
      format_code = FMT_S24;
    end else begin
      format_code = FMT_S16;
    end

    state_next = cur;
    emit       = '0;

    if (!cur.finished) begin
      if (item.stream_end) begin
        emit.valid = 1'b1;
        case (cur.phase)
          PH_HEAD, PH_HEAD_BAD: emit.result = error_result(ST_SHORT_HEADER);
          PH_FMT:               emit.result = error_result(ST_BAD_FMT);
          default:              emit.result = error_result(ST_MISSING_DATA);
        endcase
      end else begin
        state_next.position = cur.position + 33'd1;
        state_next.window   = win;
        case (cur.phase)
          PH_HEAD, PH_HEAD_BAD: begin
            state_next.count = cnt_inc;
            if (cnt_inc == HEAD_RIFF_END && win[31:0] != ID_RIFF) begin
              state_next.phase = PH_HEAD_BAD;
            end
            if (cnt_inc == HEAD_END) begin
              if (cur.phase == PH_HEAD_BAD || win[31:0] != ID_WAVE) begin
                emit.valid  = 1'b1;
                emit.result = error_result(ST_NOT_RIFF_WAVE);
              end else begin
                state_next.phase = PH_CHUNK;
                state_next.count = '0;
              end
            end
          end
          PH_CHUNK: begin
            state_next.count = cnt_inc;
            if (cnt_inc == CHUNK_HDR_END) begin
              state_next.chunk_len = le32;
              state_next.count     = '0;
              if (win[63:32] == ID_FMT) begin
                if (le32 < FMT_MIN_SIZE) begin
                  emit.valid  = 1'b1;
                  emit.result = error_result(ST_BAD_FMT);
                end else begin
                  state_next.phase = PH_FMT;
                end
              end else if (win[63:32] == ID_DATA) begin
                emit.valid                = 1'b1;
                emit.result.status        = data_status;
                emit.result.channel_count = cur.held_channels;
                emit.result.sample_rate   = cur.held_rate;
                emit.result.sample_bits   = cur.held_bits;
                emit.result.payload_size  = le32;
                emit.result.data_offset   = state_next.position;
                emit.result.sample_format = format_code;
              end else begin
                state_next.count = skip_chunk;
                state_next.phase = (skip_chunk == '0) ? PH_CHUNK : PH_SKIP;
              end
            end
          end
          PH_FMT: begin
            state_next.count = cnt_inc;
            if (cnt_inc == FMT_TAG_END) begin
              state_next.format_tag = le16;
            end else if (cnt_inc == FMT_CH_END) begin
              state_next.held_channels = le16;
            end else if (cnt_inc == FMT_RATE_END) begin
              state_next.held_rate = le32;
            end else if (cnt_inc == FMT_END) begin
              state_next.held_bits = le16;
              if (cur.format_tag != FORMAT_PCM) begin
                emit.valid  = 1'b1;
                emit.result = error_result(ST_NON_PCM);
              end else begin
                state_next.format_seen = 1'b1;
                state_next.count       = skip_fmt;
                state_next.phase       = (skip_fmt == '0) ? PH_CHUNK : PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            state_next.count = cur.count - 33'd1;
            if (state_next.count == '0) begin
              state_next.phase = PH_CHUNK;
            end
          end
          default: begin
            state_next = cur;
          end
        endcase
      end
      if (emit.valid) begin
        state_next.finished = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (take) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wrp_out_reg.sv
`default_nettype none

module wrp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  wrp_pkg::wrp_emit_t  emit,
  output logic                result_valid,
  input  logic                result_ready,
  output wrp_pkg::wrp_result_t result
);
  import wrp_pkg::*;

  logic load;

  assign load = take && emit.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= emit.result;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wrp_checker.sv
`default_nettype none

`include "wav_riff_header_parser_defines.svh"

module wrp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_ready,
  input wrp_pkg::wrp_result_t result
);
  import wrp_pkg::*;

  logic       is_error;
  logic       is_meta;
  logic       meta_zero;
  logic       ok_fields;
  logic [1:0] format_want;

  assign is_error = result.status == ST_SHORT_HEADER || result.status == ST_NOT_RIFF_WAVE ||
                    result.status == ST_MISSING_DATA || result.status == ST_BAD_FMT ||
                    result.status == ST_NON_PCM;
  assign is_meta = result.status == ST_OK || result.status == ST_INCOMPLETE ||
                   result.status == ST_BAD_BITS;
  assign meta_zero = result.channel_count == '0 && result.sample_rate == '0 &&
                     result.sample_bits == '0 && result.payload_size == '0 &&
                     result.data_offset == '0 && result.sample_format == FMT_S16;
  assign ok_fields = result.channel_count != '0 && result.sample_rate != '0 &&
                     result.payload_size != '0 &&
                     (result.sample_bits == BITS_16 || result.sample_bits == BITS_24 ||
                      result.sample_bits == BITS_32);
  assign format_want = (result.sample_bits == BITS_32) ? FMT_S32 :
                       (result.sample_bits == BITS_24) ? FMT_S24 : FMT_S16;

  `WRP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

  `WRP_ASSERT_IMP(a_error_fields_zero, result_valid && is_error, meta_zero)

  `WRP_ASSERT_IMP(a_format_code, result_valid && is_meta, result.sample_format == format_want)

  `WRP_ASSERT_IMP(a_ok_complete, result_valid && result.status == ST_OK, ok_fields)

endmodule

bind wav_riff_header_parser wrp_checker u_checker (.*);

`default_nettype wire
